[rtl/bdre_pkg.sv]
// Package for the block delta run encoder.
// Sizes, run limits, controller states and the command/status structs.
// Used by bdre_ctrl, bdre_dp and block_delta_run_encoder_top.
package bdre_pkg;

  localparam int MAX_LITERAL = 32;
  localparam int LIT_AW      = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int CNT_W       = $clog2(MAX_LITERAL + 1);
  localparam int EQ_W        = 15;
  localparam int TOK_W       = 16;

  localparam logic [EQ_W-1:0]  EQ_RUN_MAX   = 15'h7FFF;
  localparam logic [TOK_W-1:0] CHANGED_FLAG = 16'h8000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_EQM,
    S_CHM,
    S_LRD,
    S_LWR,
    S_UPD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic inc_eq;
    logic wr_lit;
    logic clr_cc;
    logic emit_eq;
    logic emit_chm;
    logic emit_lit;
    logic rd_lit;
    logic idx_clr;
    logic idx_inc;
    logic last;
    logic done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_eq;
    logic blk_end;
    logic eq_zero;
    logic cc_zero;
    logic run_full;
    logic lit_last;
    logic slot_free;
  } stat_t;

endpackage

[rtl/bdre_ctrl.sv]
// Sequencer for the block delta run encoder.
// Steps each item through flush of the prior run, count update and own flush.
// Depends on bdre_pkg.
module bdre_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bdre_pkg::stat_t stat,
  output bdre_pkg::cmd_t  cmd
);
  import bdre_pkg::*;

  state_t state;
  state_t state_next;
  logic   pre;       // emitting the run that this item closes
  logic   pre_next;
  logic   bneed;     // this item's own run gets flushed after update
  logic   bneed_next;
  logic   tok_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pre   <= 1'b0;
      bneed <= 1'b0;
    end else begin
      state <= state_next;
      pre   <= pre_next;
      bneed <= bneed_next;
    end
  end

  always_comb begin
    pre_next   = pre;
    bneed_next = bneed;
    if (state == S_CHK) begin
      pre_next   = 1'b1;
      bneed_next = stat.run_full | stat.blk_end;
    end else if (state == S_UPD) begin
      pre_next = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.is_eq && !stat.cc_zero)       state_next = S_CHM;
        else if (!stat.is_eq && !stat.eq_zero) state_next = S_EQM;
        else                                   state_next = S_UPD;
      end
      S_EQM: begin
        if (stat.slot_free) state_next = pre ? S_UPD : S_IDLE;
      end
      S_CHM: begin
        if (stat.slot_free) state_next = S_LRD;
      end
      S_LRD: begin
        state_next = S_LWR;
      end
      S_LWR: begin
        if (stat.slot_free) begin
          if (stat.lit_last) state_next = pre ? S_UPD : S_IDLE;
          else               state_next = S_LRD;
        end
      end
      S_UPD: begin
        if (bneed) state_next = stat.is_eq ? S_EQM : S_CHM;
        else       state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  assign tok_last = pre ? !bneed : 1'b1;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_CHK: begin
      end
      S_EQM: begin
        cmd.emit_eq = stat.slot_free;
        cmd.last    = tok_last;
        cmd.done    = tok_last & stat.blk_end;
      end
      S_CHM: begin
        cmd.emit_chm = stat.slot_free;
        cmd.idx_clr  = stat.slot_free;
      end
      S_LRD: begin
        cmd.rd_lit = 1'b1;
      end
      S_LWR: begin
        cmd.emit_lit = stat.slot_free;
        cmd.idx_inc  = stat.slot_free & !stat.lit_last;
        cmd.clr_cc   = stat.slot_free & stat.lit_last;
        cmd.last     = stat.lit_last & tok_last;
        cmd.done     = stat.lit_last & tok_last & stat.blk_end;
      end
      S_UPD: begin
        cmd.inc_eq = stat.is_eq;
        cmd.wr_lit = !stat.is_eq;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/bdre_dp.sv]
// Datapath of the block delta run encoder.
// Run counters, literal buffer memory, item latch and output register.
// Depends on bdre_pkg.
module bdre_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 old_byte,
  input  logic [7:0]                 new_byte,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bdre_pkg::TOK_W-1:0] token_value,
  output logic                       is_marker,
  output logic                       last_of_item,
  output logic                       block_done,
  input  bdre_pkg::cmd_t             cmd,
  output bdre_pkg::stat_t            stat
);
  import bdre_pkg::*;

  logic             is_eq;
  logic [7:0]       new_r;
  logic             blk_r;
  logic [EQ_W-1:0]  eq_cnt;
  logic [CNT_W-1:0] cc;
  logic [LIT_AW-1:0] idx;
  logic [7:0]       rd_data;
  logic [7:0]       lit_mem [MAX_LITERAL];
  logic             emit_any;

  assign emit_any = cmd.emit_eq | cmd.emit_chm | cmd.emit_lit;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_eq <= (old_byte == new_byte);
      new_r <= new_byte;
      blk_r <= block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_cnt <= '0;
      cc     <= '0;
    end else begin
      if (cmd.emit_eq)     eq_cnt <= '0;
      else if (cmd.inc_eq) eq_cnt <= eq_cnt + EQ_W'(1);
      if (cmd.clr_cc)      cc <= '0;
      else if (cmd.wr_lit) cc <= cc + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_lit) lit_mem[cc[LIT_AW-1:0]] <= new_r;
    if (cmd.rd_lit) rd_data <= lit_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr)      idx <= '0;
    else if (cmd.idx_inc) idx <= idx + LIT_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      last_of_item <= cmd.last;
      block_done   <= cmd.done;
      is_marker    <= !cmd.emit_lit;
      if (cmd.emit_eq)       token_value <= {1'b0, eq_cnt};
      else if (cmd.emit_chm) token_value <= CHANGED_FLAG | TOK_W'(cc);
      else                   token_value <= {8'h00, rd_data};
    end
  end

  // run_full: the count after this item's update hits its split limit
  always_comb begin
    stat.is_eq     = is_eq;
    stat.blk_end   = blk_r;
    stat.eq_zero   = (eq_cnt == '0);
    stat.cc_zero   = (cc == '0);
    stat.run_full  = is_eq ? ((eq_cnt + EQ_W'(1)) == EQ_RUN_MAX)
                           : ((cc + CNT_W'(1)) == CNT_W'(MAX_LITERAL));
    stat.lit_last  = ((CNT_W'(idx) + CNT_W'(1)) == cc);
    stat.slot_free = !out_valid | out_ready;
  end

endmodule

[rtl/block_delta_run_encoder_top.sv]
// Top level of the block delta run encoder: controller plus datapath.
// Depends on bdre_pkg, bdre_ctrl, bdre_dp.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | old_byte, new_byte, block_end
//   out     | output    | out_valid / out_ready| token_value, is_marker, last_of_item,
//           |           |                      | block_done
//
// One item at a time. An item that emits nothing passes through accept, check and
// update; an equal marker adds an emit state, and a changed run adds a marker state and,
// for every literal, one registered read of the literal buffer and one output load.
// Reset is synchronous and clears both run counts; no clearing pass is needed.
// A stalled output holds the sequencer in its emit state; the last token of an item
// may still wait in the output register while the next item is accepted.
module block_delta_run_encoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 old_byte,
  input  logic [7:0]                 new_byte,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bdre_pkg::TOK_W-1:0] token_value,
  output logic                       is_marker,
  output logic                       last_of_item,
  output logic                       block_done
);
  import bdre_pkg::*;

  cmd_t   cmd;
  stat_t  stat;

  bdre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdre_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .old_byte     (old_byte),
    .new_byte     (new_byte),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_value  (token_value),
    .is_marker    (is_marker),
    .last_of_item (last_of_item),
    .block_done   (block_done),
    .cmd          (cmd),
    .stat         (stat)
  );

  // only one kind of run is ever pending
  a_one_run: assert property (@(posedge clk) disable iff (rst)
    stat.eq_zero || stat.cc_zero)
    else $error("equal and changed runs pending together");

  // a token is loaded only into a free output slot
  a_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_eq || cmd.emit_chm || cmd.emit_lit) |-> stat.slot_free)
    else $error("output register overwritten");

  // one item at a time
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  // end of block token always closes its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_done) |-> last_of_item)
    else $error("block_done without last_of_item");

endmodule
